/* sv/psuc_pkg.sv */
// ----------------------------------------------------------------------------
// psuc_pkg: shared types and constants for the PNG scanline unfilter checker
// Holds the filter and status codes, register indexes, the per-request
// control record passed between the stages, and the Paeth predictor.
// ----------------------------------------------------------------------------
package psuc_pkg;

    // Default build limits.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Configuration field widths and reset values.
    localparam int DIM_W   = 11;
    localparam int COUNT_W = 21;
    localparam int CFG_W   = 21;
    localparam logic [DIM_W-1:0]   WIDTH_RESET   = 11'd1008;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET  = 11'd1008;
    localparam logic [COUNT_W-1:0] MIN_VIS_RESET = 21'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_WIDTH       = 2'd0,
        REG_HEIGHT      = 2'd1,
        REG_MIN_VISIBLE = 2'd2
    } cfg_index_t;

    // Row filter types.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // Image status reported with the final byte.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_FILTER  = 2'd1,
        ST_BAD_LENGTH  = 2'd2,
        ST_NOT_VISIBLE = 2'd3
    } status_t;

    // Control record for one request, handed from the control stage to the
    // reconstruction stage.
    typedef struct packed {
        logic [7:0] data;
        logic       sample;
        logic       first_row;
        logic       last;
        filter_t    filter;
        status_t    pre_status;
        logic       check_vis;
    } item_ctl_t;

    // One result.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        status_t    status;
    } result_t;

    // Paeth predictor without signed arithmetic:
    // |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
    function automatic logic [7:0] paeth_pick(input logic [7:0] a,
                                              input logic [7:0] b,
                                              input logic [7:0] c);
        logic [7:0] da;
        logic [7:0] db;
        logic [8:0] sum_ab;
        logic [8:0] twice_c;
        logic [8:0] dc;
        da      = (b > c) ? (b - c) : (c - b);
        db      = (a > c) ? (a - c) : (c - a);
        sum_ab  = {1'b0, a} + {1'b0, b};
        twice_c = {c, 1'b0};
        dc      = (sum_ab > twice_c) ? (sum_ab - twice_c) : (twice_c - sum_ab);
        if (({1'b0, da} <= {1'b0, db}) && ({1'b0, da} <= dc))
        begin
            return a;
        end
        return ({1'b0, db} <= dc) ? b : c;
    endfunction

endpackage

/* sv/psuc_in_if.sv */
// ----------------------------------------------------------------------------
// psuc_in_if: inflated byte stream channel
// Valid/ready channel carrying one stream byte and its end marker.
// ----------------------------------------------------------------------------
interface psuc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_data;

    modport source (output valid, output in_byte, output end_of_data, input ready);
    modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

/* sv/psuc_out_if.sv */
// ----------------------------------------------------------------------------
// psuc_out_if: reconstructed byte channel
// Valid/ready channel carrying one rebuilt byte and the image status.
// ----------------------------------------------------------------------------
interface psuc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] status;

    modport source (output valid, output out_byte, output byte_valid,
                    output done_res, output status, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input done_res, input status, output ready);
endinterface

/* sv/psuc_cfg_if.sv */
// ----------------------------------------------------------------------------
// psuc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface psuc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [20:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/psuc_line_mem.sv */
// ----------------------------------------------------------------------------
// psuc_line_mem: line store
// One-port-write, one-port-read synchronous RAM holding the previous row.
// Read data is registered and held while no read is issued.
// ----------------------------------------------------------------------------
module psuc_line_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/psuc_ctrl.sv */
// ----------------------------------------------------------------------------
// psuc_ctrl: stream position control
// Tracks column, row, row filter, overrun and filter error per request,
// issues the line store read address and judges the stream length.
// ----------------------------------------------------------------------------
module psuc_ctrl
    import psuc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int AW         = $clog2(4 * MAX_WIDTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             end_of_data,
    input  logic [DIM_W-1:0] image_width,
    input  logic [DIM_W-1:0] image_height,
    output logic [AW-1:0]    rd_addr,
    output item_ctl_t        item_ctl_reg,
    output logic [AW-1:0]    item_addr_reg
);

    localparam int LINE_BYTES = 4 * MAX_WIDTH;
    localparam int CW         = $clog2(LINE_BYTES + 1);
    localparam int RW         = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    filter_t       filter_reg, filter_next;
    logic          ovr_reg, ovr_next;
    logic          err_reg, err_next;
    logic [31:0]   width32, height32, ew32, eh32;
    logic [CW-1:0] line_len;
    logic [RW-1:0] eh;
    logic          complete;
    item_ctl_t     ctl;

    // Clamp the configured dimensions to the range from one to the build limits.
    always_comb
    begin
        width32  = 32'(image_width);
        height32 = 32'(image_height);
        if (width32 == 32'd0)
        begin
            ew32 = 32'd1;
        end
        else if (width32 > 32'(MAX_WIDTH))
        begin
            ew32 = 32'(MAX_WIDTH);
        end
        else
        begin
            ew32 = width32;
        end
        if (height32 == 32'd0)
        begin
            eh32 = 32'd1;
        end
        else if (height32 > 32'(MAX_HEIGHT))
        begin
            eh32 = 32'(MAX_HEIGHT);
        end
        else
        begin
            eh32 = height32;
        end
    end

    assign line_len = CW'(ew32 * 32'd4);
    assign eh       = RW'(eh32);
    assign rd_addr  = AW'(col_reg - CW'(1));

    // Next position and the control record for this request.
    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        filter_next      = filter_reg;
        ovr_next         = ovr_reg;
        err_next         = err_reg;
        complete         = 1'b0;
        ctl.data         = in_byte;
        ctl.sample       = 1'b0;
        ctl.first_row    = (row_reg == '0);
        ctl.last         = end_of_data;
        ctl.filter       = filter_reg;
        ctl.pre_status   = ST_OK;
        ctl.check_vis    = 1'b0;

        if (row_reg >= eh)
        begin
            ovr_next = 1'b1;
        end
        else if (col_reg == '0)
        begin
            if (in_byte > 8'(FILT_PAETH))
            begin
                err_next    = 1'b1;
                filter_next = FILT_NONE;
            end
            else
            begin
                filter_next = filter_t'(in_byte[2:0]);
            end
            col_next = CW'(1);
        end
        else
        begin
            ctl.sample = 1'b1;
            if (col_reg >= line_len)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end

        // Length and filter verdict on the final byte, then restart.
        if (end_of_data)
        begin
            complete = !ovr_next && (row_next >= eh) && (col_next == '0);
            if (!complete)
            begin
                ctl.pre_status = ST_BAD_LENGTH;
            end
            else if (err_next)
            begin
                ctl.pre_status = ST_BAD_FILTER;
            end
            else
            begin
                ctl.check_vis = 1'b1;
            end
            col_next    = '0;
            row_next    = '0;
            filter_next = FILT_NONE;
            ovr_next    = 1'b0;
            err_next    = 1'b0;
        end
    end

    // Position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            filter_reg <= FILT_NONE;
            ovr_reg    <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            filter_reg <= filter_next;
            ovr_reg    <= ovr_next;
            err_reg    <= err_next;
        end
    end

    // Stage register toward reconstruction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_ctl_reg  <= ctl;
            item_addr_reg <= rd_addr;
        end
    end

endmodule

/* sv/psuc_recon.sv */
// ----------------------------------------------------------------------------
// psuc_recon: sample reconstruction and image statistics
// Applies the inverse filter from the left, upper and upper-left bytes,
// writes the rebuilt byte back to the line store and keeps pixel statistics.
// ----------------------------------------------------------------------------
module psuc_recon
    import psuc_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  item_ctl_t          item_ctl,
    input  logic [AW-1:0]      item_addr,
    input  logic [7:0]         rd_data,
    input  logic [COUNT_W-1:0] min_visible,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [7:0]         wr_data,
    output result_t            result
);

    logic [31:0]        left_reg, left_next;
    logic [31:0]        upleft_reg, upleft_next;
    logic [23:0]        gather_reg, gather_next;
    logic [31:0]        first_reg, first_next;
    logic               seen_reg, seen_next;
    logic               varied_reg, varied_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [1:0]         sh;
    logic [4:0]         base;
    logic               has_left;
    logic [7:0]         left_b, up_b, ul_b, pred, ob;
    logic [31:0]        px;

    assign sh       = item_addr[1:0];
    assign base     = {sh, 3'b000};
    assign has_left = (32'(item_addr) >= 32'd4);
    assign left_b   = has_left ? left_reg[base +: 8] : 8'd0;
    assign ul_b     = has_left ? upleft_reg[base +: 8] : 8'd0;
    assign up_b     = item_ctl.first_row ? 8'd0 : rd_data;

    // Predictor selection by row filter.
    always_comb
    begin
        case (item_ctl.filter)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = left_b;
            FILT_UP:    pred = up_b;
            FILT_AVG:   pred = 8'(({1'b0, left_b} + {1'b0, up_b}) >> 1);
            FILT_PAETH: pred = paeth_pick(left_b, up_b, ul_b);
            default:    pred = 8'd0;
        endcase
    end

    assign ob = item_ctl.data + pred;
    assign px = {ob, gather_reg};

    // Neighbor bytes, pixel statistics and the result.
    always_comb
    begin
        left_next   = left_reg;
        upleft_next = upleft_reg;
        gather_next = gather_reg;
        first_next  = first_reg;
        seen_next   = seen_reg;
        varied_next = varied_reg;
        count_next  = count_reg;

        if (item_ctl.sample)
        begin
            left_next[base +: 8]   = ob;
            upleft_next[base +: 8] = up_b;
            case (sh)
                2'd0:    gather_next[7:0]   = ob;
                2'd1:    gather_next[15:8]  = ob;
                2'd2:    gather_next[23:16] = ob;
                default:
                begin
                    if (!seen_reg)
                    begin
                        first_next = px;
                        seen_next  = 1'b1;
                    end
                    else if (px != first_reg)
                    begin
                        varied_next = 1'b1;
                    end
                    if ((ob != 8'd0) && (count_reg != COUNT_MAX))
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            endcase
        end

        result.out_byte   = item_ctl.sample ? ob : 8'd0;
        result.byte_valid = item_ctl.sample;
        result.done_res   = item_ctl.last;
        result.status     = ST_OK;

        // Final verdict and restart of the image statistics.
        if (item_ctl.last)
        begin
            if (!item_ctl.check_vis)
            begin
                result.status = item_ctl.pre_status;
            end
            else if ((count_next < min_visible) || !varied_next)
            begin
                result.status = ST_NOT_VISIBLE;
            end
            left_next   = '0;
            upleft_next = '0;
            gather_next = '0;
            first_next  = '0;
            seen_next   = 1'b0;
            varied_next = 1'b0;
            count_next  = '0;
        end
    end

    // Line store write-back.
    assign wr_en   = adv && item_ctl.sample;
    assign wr_addr = item_addr;
    assign wr_data = ob;

    // Statistics state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            upleft_reg <= '0;
            gather_reg <= '0;
            first_reg  <= '0;
            seen_reg   <= 1'b0;
            varied_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (adv)
        begin
            left_reg   <= left_next;
            upleft_reg <= upleft_next;
            gather_reg <= gather_next;
            first_reg  <= first_next;
            seen_reg   <= seen_next;
            varied_reg <= varied_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/png_scanline_unfilter_checker.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter_checker: streaming PNG RGBA8 unfilter and checker
// Pipeline: an accepted byte is held in the control stage register, then moves
// to the output register when the output slot frees.
// Throughput: one byte per cycle while the output does not stall; the line
// store is read in the control stage and written back in the reconstruction stage of the same request.
// Reset: position, statistics and handshake state clear, configuration returns
// to width 1008, height 1008, min_visible 16; the line store is not cleared,
// as the first row of each image reads zero for the upper neighbors.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_checker
    import psuc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    psuc_in_if.sink     in_ch,
    psuc_out_if.source  out_ch,
    psuc_cfg_if.sink    cfg
);

    localparam int LINE_BYTES = 4 * MAX_WIDTH;
    localparam int AW         = $clog2(LINE_BYTES);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COUNT_W-1:0] min_vis_reg;
    logic               s1_valid_reg, s1_valid_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;
    result_t            result;
    item_ctl_t          item_ctl;
    logic [AW-1:0]      item_addr;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic               adv;
    logic               accept;

    // Handshake: the reconstruction stage moves when the output slot frees.
    assign adv         = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || adv;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        out_valid_next = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_reg.out_byte;
    assign out_ch.byte_valid = out_reg.byte_valid;
    assign out_ch.done_res   = out_reg.done_res;
    assign out_ch.status     = out_reg.status;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            min_vis_reg <= MIN_VIS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_WIDTH:       width_reg   <= cfg.data[DIM_W-1:0];
                REG_HEIGHT:      height_reg  <= cfg.data[DIM_W-1:0];
                REG_MIN_VISIBLE: min_vis_reg <= cfg.data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Stream position control.
    psuc_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_ch.in_byte),
        .end_of_data   (in_ch.end_of_data),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .rd_addr       (rd_addr),
        .item_ctl_reg  (item_ctl),
        .item_addr_reg (item_addr)
    );

    // Previous-row store.
    psuc_line_mem #(
        .DEPTH (LINE_BYTES),
        .AW    (AW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Sample reconstruction and statistics.
    psuc_recon #(
        .AW (AW)
    ) u_recon (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item_ctl    (item_ctl),
        .item_addr   (item_addr),
        .rd_data     (rd_data),
        .min_visible (min_vis_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .result      (result)
    );

    // A status other than ok only comes with the final byte.
    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.done_res) |-> (out_reg.status == ST_OK))
        else $error("status set on a result that is not the final one");

    // Non-sample results carry a zero byte.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.byte_valid) |-> (out_reg.out_byte == 8'd0))
        else $error("nonzero byte on a non-sample result");

    // The line store is written only when a sample moves to the output.
    a_write_with_adv: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (adv && s1_valid_reg && result.byte_valid))
        else $error("line store written without a sample advancing");

    // A result that advances is presented in the next cycle.
    a_adv_presents: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advanced result not presented");

endmodule
